// File: sv/cpms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpms_pkg
// Shared constants for the cuff pressure measurement sequencer.
// ----------------------------------------------------------------------------
package cpms_pkg;

    localparam int unsigned PW = 17;

    // Sensor scaling constants.
    localparam logic [23:0] RAW_MIN  = 24'd419430;
    localparam logic [21:0] RAW_SPAN = 22'd3355443;
    localparam logic [PW-1:0] P_MAX  = 17'd76800;

    // Scaling by 76800 / 3355443, reduced to 25600 / 1118481, done as a
    // multiply by a rounded-up reciprocal and a right shift. The result is
    // exact for every offset below the span.
    localparam int unsigned SC_SHIFT  = 43;
    localparam logic [37:0] SC_MUL    =
        38'(((64'd25600 << SC_SHIFT) + 64'd1118480) / 64'd1118481);
    localparam logic [19:0] SC_MUL_LO = SC_MUL[19:0];
    localparam logic [17:0] SC_MUL_HI = SC_MUL[37:20];

    // Inflate progress band edges, 1/256 mmHg.
    localparam logic [PW-1:0] BAND1_LO = 17'd17920;
    localparam logic [PW-1:0] BAND2_LO = 17'd25600;
    localparam logic [PW-1:0] BAND3_LO = 17'd33280;
    localparam logic [PW-1:0] BAND4_LO = 17'd40960;

    // Stage codes.
    localparam logic [2:0] PH_IDLE    = 3'd1;
    localparam logic [2:0] PH_INFLATE = 3'd2;
    localparam logic [2:0] PH_HOLD    = 3'd3;
    localparam logic [2:0] PH_DEFLATE = 3'd4;
    localparam logic [2:0] PH_REPORT  = 3'd5;

    // Sample error codes.
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_BUSY = 2'd1;
    localparam logic [1:0] ERR_MEM  = 2'd2;
    localparam logic [1:0] ERR_SAT  = 2'd3;

    // Deflation classes.
    localparam logic [1:0] DC_NONE = 2'd0;
    localparam logic [1:0] DC_FAST = 2'd1;
    localparam logic [1:0] DC_SLOW = 2'd2;
    localparam logic [1:0] DC_GOOD = 2'd3;

    // Register indexes.
    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_FULL  = 3'd1;
    localparam logic [2:0] REG_STOP  = 3'd2;
    localparam logic [2:0] REG_HOLD  = 3'd3;
    localparam logic [2:0] REG_FAST  = 3'd4;
    localparam logic [2:0] REG_SLOW  = 3'd5;

endpackage
`default_nettype wire

// File: sv/cuff_pressure_measure_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cuff_pressure_measure_sequencer
// Scales and averages cuff pressure samples and runs the measurement stages.
// ----------------------------------------------------------------------------
// Channel  | Dir | tdata (low bit first)                  | tuser
// s_       | in  | raw_count[23:0]                        | sensor_status[7:0]
// m_       | out | phase,avg_pressure,progress_band,      | sample_error[1:0]
//          |     | blink_on,deflate_class,report_valid,   |
//          |     | systolic_level,peak_level,beat_total,  |
//          |     | tick_total (96 bits, zero filled)      |
// An item runs through these steps from one accept to the next: the accept,
// the low and high halves of the scaling reciprocal on the shared multiplier,
// clamp and store of the sample, the sum of the window over AVG_TAPS taps, a
// multiply by the reciprocal of AVG_TAPS, and the stage update with the result.
// Reset is synchronous and active low. s_tready is high only while idle; a
// result that is not taken holds the block in S_OUT until it is.
// ----------------------------------------------------------------------------
module cuff_pressure_measure_sequencer
    import cpms_pkg::*;
#(
    parameter int unsigned AVG_TAPS   = 5,
    parameter int unsigned RATE_DEPTH = 10
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // raw_count
    input  wire logic [7:0]   s_tuser,   // sensor_status
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // phase[2:0], avg_pressure[19:3], progress_band[22:20], blink_on[23],
    // deflate_class[25:24], report_valid[26], systolic_level[43:27],
    // peak_level[60:44], beat_total[76:61], tick_total[92:77]
    output logic [95:0]       m_tdata,
    output logic [1:0]        m_tuser,   // sample_error
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [16:0]  cfg_data
);

    localparam int unsigned AW  = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
    localparam int unsigned HW  = $clog2(RATE_DEPTH);
    localparam int unsigned SW  = PW + $clog2(AVG_TAPS + 1);
    localparam int unsigned MAW = 22;
    localparam int unsigned MBW = SW + 5;
    localparam int unsigned AVG_K = SW + 4;
    localparam logic [MBW-1:0] AVG_M =
        MBW'(((64'd1 << AVG_K) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_WIN, S_SUM, S_AVG, S_OUT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [PW-1:0] start_reg, full_reg, stop_reg, fast_reg, slow_reg;
    logic [7:0]    holdt_reg;

    // Item and arithmetic working registers.
    logic [7:0]    status_reg;
    logic [23:0]   raw_reg;
    logic [59:0]   acc_reg;
    logic [AW-1:0] cnt_reg;
    logic [SW-1:0] sum_reg;
    logic [PW-1:0] p_reg;

    // Block state.
    logic [PW-1:0] win_reg [AVG_TAPS];
    logic [AW-1:0] slot_reg;
    logic [PW-1:0] hist_reg [RATE_DEPTH];
    logic [HW-1:0] hslot_reg;
    logic [2:0]    phase_reg;
    logic [7:0]    holdc_reg;
    logic          blink_reg, found_reg, rising_reg;
    logic [PW-1:0] prev_reg, sys_reg, bottom_reg, swing_reg, peak_reg;
    logic [15:0]   beats_reg, ticks_reg;

    // Result fields.
    logic [1:0]    err_reg, dcl_reg;
    logic [2:0]    pband_reg;
    logic          rep_reg;
    logic [PW-1:0] oavg_reg, osys_reg, opeak_reg;
    logic [15:0]   obeat_reg, otick_reg;

    // Shared multiplier: scaling reciprocal halves, then the tap reciprocal.
    logic [23:0]        off_v;
    logic               low_v, high_v;
    logic [MAW-1:0]     mul_a;
    logic [MBW-1:0]     mul_b;
    logic [MAW+MBW-1:0] prod;
    always_comb begin
        off_v  = raw_reg - RAW_MIN;
        low_v  = (raw_reg < RAW_MIN);
        high_v = (off_v >= {2'b00, RAW_SPAN});
        if (state_reg == S_AVG) begin
            mul_a = MAW'(sum_reg);
            mul_b = AVG_M;
        end else begin
            mul_a = off_v[21:0];
            mul_b = (state_reg == S_ACC) ? MBW'(SC_MUL_HI) : MBW'(SC_MUL_LO);
        end
        prod = mul_a * mul_b;
    end

    // Deflation helpers.
    logic [HW-1:0] nx_slot;
    logic [PW-1:0] old_lvl, rate_v, swing_v;
    always_comb begin
        nx_slot = (32'(hslot_reg) + 1 >= RATE_DEPTH) ? '0 : HW'(hslot_reg + 1'b1);
        old_lvl = hist_reg[nx_slot];
        rate_v  = (p_reg > old_lvl) ? p_reg - old_lvl : old_lvl - p_reg;
        swing_v = p_reg - bottom_reg;
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            m_tvalid   <= 1'b0;
            start_reg  <= 17'd7680;
            full_reg   <= 17'd43520;
            stop_reg   <= 17'd12800;
            holdt_reg  <= 8'd20;
            fast_reg   <= 17'd1280;
            slow_reg   <= 17'd256;
            for (int i = 0; i < AVG_TAPS; i++) win_reg[i] <= '0;
            slot_reg   <= '0;
            hslot_reg  <= '0;
            phase_reg  <= PH_IDLE;
            holdc_reg  <= '0;
            blink_reg  <= 1'b0;
            found_reg  <= 1'b0;
            rising_reg <= 1'b0;
            prev_reg   <= '0;
            sys_reg    <= '0;
            bottom_reg <= '0;
            swing_reg  <= '0;
            peak_reg   <= '0;
            beats_reg  <= '0;
            ticks_reg  <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_START: start_reg <= cfg_data;
                    REG_FULL:  full_reg  <= cfg_data;
                    REG_STOP:  stop_reg  <= cfg_data;
                    REG_HOLD:  holdt_reg <= cfg_data[7:0];
                    REG_FAST:  fast_reg  <= cfg_data;
                    REG_SLOW:  slow_reg  <= cfg_data;
                    default: ;
                endcase
            end
            // A new result goes out once the last one is taken.
            if (state_reg == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        status_reg <= s_tuser;
                        raw_reg    <= s_tdata;
                        state_reg  <= S_MUL;
                    end
                end
                // Low half of the scaling reciprocal.
                S_MUL: begin
                    acc_reg   <= 60'(prod);
                    state_reg <= S_ACC;
                end
                // High half, added in at its weight.
                S_ACC: begin
                    acc_reg   <= acc_reg + (60'(prod) << 20);
                    state_reg <= S_WIN;
                end
                // Clamp the scaled sample and store it unless it is flagged.
                S_WIN: begin
                    if (!(status_reg[5] || status_reg[2] || status_reg[0])) begin
                        win_reg[slot_reg] <= low_v ? '0
                                             : (high_v ? P_MAX : acc_reg[59:43]);
                        slot_reg <= (32'(slot_reg) + 1 >= AVG_TAPS) ? '0
                                    : AW'(slot_reg + 1'b1);
                    end
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_SUM;
                end
                // Sum the window one tap per cycle.
                S_SUM: begin
                    sum_reg <= sum_reg + SW'(win_reg[cnt_reg]);
                    if (32'(cnt_reg) == AVG_TAPS - 1) begin
                        state_reg <= S_AVG;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                // Divide the sum by the tap count through its reciprocal.
                S_AVG: begin
                    p_reg     <= prod[AVG_K +: PW];
                    state_reg <= S_OUT;
                end
                // Stage machine update and result capture.
                S_OUT: begin
                    if (!m_tvalid || m_tready) begin
                        priority if (status_reg[5]) err_reg <= ERR_BUSY;
                        else if (status_reg[2]) err_reg <= ERR_MEM;
                        else if (status_reg[0]) err_reg <= ERR_SAT;
                        else err_reg <= ERR_OK;
                        pband_reg <= '0;
                        dcl_reg   <= DC_NONE;
                        rep_reg   <= 1'b0;
                        oavg_reg  <= p_reg;
                        osys_reg  <= '0;
                        opeak_reg <= '0;
                        obeat_reg <= '0;
                        otick_reg <= '0;
                        state_reg <= S_IDLE;
                        unique case (phase_reg)
                            PH_INFLATE: begin
                                priority if (p_reg > BAND1_LO && p_reg < BAND2_LO)
                                    pband_reg <= 3'd1;
                                else if (p_reg > BAND2_LO && p_reg < BAND3_LO)
                                    pband_reg <= 3'd2;
                                else if (p_reg > BAND3_LO && p_reg < BAND4_LO)
                                    pband_reg <= 3'd3;
                                else if (p_reg > BAND4_LO)
                                    pband_reg <= 3'd4;
                                if (p_reg > full_reg) phase_reg <= PH_HOLD;
                            end
                            PH_HOLD: begin
                                hist_reg[hslot_reg] <= p_reg;
                                hslot_reg <= nx_slot;
                                if (holdc_reg > holdt_reg) begin
                                    phase_reg  <= PH_DEFLATE;
                                    blink_reg  <= 1'b0;
                                    holdc_reg  <= '0;
                                    prev_reg   <= p_reg;
                                    beats_reg  <= '0;
                                    ticks_reg  <= '0;
                                    swing_reg  <= '0;
                                    found_reg  <= 1'b0;
                                    rising_reg <= 1'b0;
                                end else begin
                                    blink_reg <= ~blink_reg;
                                    if (holdc_reg != 8'hFF)
                                        holdc_reg <= holdc_reg + 1'b1;
                                end
                            end
                            PH_DEFLATE: begin
                                priority if (rate_v > fast_reg) dcl_reg <= DC_FAST;
                                else if (rate_v < slow_reg) dcl_reg <= DC_SLOW;
                                else dcl_reg <= DC_GOOD;
                                hist_reg[hslot_reg] <= p_reg;
                                hslot_reg <= nx_slot;
                                if (found_reg) begin
                                    if (rising_reg && p_reg < prev_reg) begin
                                        if (p_reg > bottom_reg && swing_v > swing_reg) begin
                                            swing_reg <= swing_v;
                                            peak_reg  <= p_reg;
                                        end
                                        rising_reg <= 1'b0;
                                    end else if (!rising_reg && p_reg > prev_reg) begin
                                        bottom_reg <= p_reg;
                                        rising_reg <= 1'b1;
                                        if (beats_reg != 16'hFFFF)
                                            beats_reg <= beats_reg + 1'b1;
                                    end
                                    if (ticks_reg != 16'hFFFF)
                                        ticks_reg <= ticks_reg + 1'b1;
                                end else if (p_reg > prev_reg) begin
                                    sys_reg    <= p_reg;
                                    found_reg  <= 1'b1;
                                    rising_reg <= 1'b1;
                                    bottom_reg <= p_reg;
                                    if (beats_reg != 16'hFFFF)
                                        beats_reg <= beats_reg + 1'b1;
                                end
                                prev_reg <= p_reg;
                                if (p_reg < stop_reg) phase_reg <= PH_REPORT;
                            end
                            PH_REPORT: begin
                                rep_reg   <= 1'b1;
                                osys_reg  <= sys_reg;
                                opeak_reg <= peak_reg;
                                obeat_reg <= beats_reg;
                                otick_reg <= ticks_reg;
                                phase_reg <= PH_IDLE;
                            end
                            default: begin
                                phase_reg <= (p_reg > start_reg) ? PH_INFLATE : PH_IDLE;
                            end
                        endcase
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tuser = err_reg;
    assign m_tdata = {3'd0, otick_reg, obeat_reg, opeak_reg, osys_reg, rep_reg,
                      dcl_reg, blink_reg, pband_reg, oavg_reg, phase_reg};

endmodule
`default_nettype wire
